// File: hdl/plc_pkg.sv
// Shared types, codes and widths for the positional list core.
`default_nettype none
package plc_pkg;

    // Fixed field widths
    localparam int OP_W     = 2;
    localparam int POS_W    = 7;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;

    // Default list capacity
    localparam int CAPACITY_DEF = 32;

    // Operation codes
    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_DUMP   = 2'd2,
        OP_UNUSED = 2'd3
    } plc_op_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        STS_OK      = 2'd0,
        STS_INVALID = 2'd1,
        STS_FULL    = 2'd2,
        STS_EMPTY   = 2'd3
    } plc_status_t;

    // What every cell of the chain does this cycle
    typedef enum logic [1:0] {
        MODE_HOLD   = 2'd0,
        MODE_INSERT = 2'd1,
        MODE_DELETE = 2'd2,
        MODE_ROTATE = 2'd3
    } plc_mode_t;

    // Control broadcast to the cells
    typedef struct packed {
        plc_mode_t        mode;
        logic [POS_W-1:0] idx;
        logic [POS_W-1:0] cnt;
    } plc_ctrl_t;

    // Request word
    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] value;
    } plc_req_t;

    // Response word
    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic signed [DATA_W-1:0] data_out;
        logic [POS_W-1:0]         length;
        logic                     last;
    } plc_rsp_t;

endpackage
`default_nettype wire

// File: hdl/plc_cell.sv
// One storage cell of the list chain, holding the entry at a fixed index.
`default_nettype none
module plc_cell
    import plc_pkg::*;
#(
    parameter int IDX = 0
) (
    input  wire                      clk,
    input  plc_ctrl_t                ctrl,
    input  wire  signed [DATA_W-1:0] word,
    input  wire  signed [DATA_W-1:0] prev,
    input  wire  signed [DATA_W-1:0] next,
    input  wire  signed [DATA_W-1:0] head,
    output logic signed [DATA_W-1:0] data
);

    localparam logic [POS_W-1:0] MY_IDX  = POS_W'(IDX);
    localparam logic [POS_W-1:0] MY_IDX1 = POS_W'(IDX + 1);

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;

    // Pick the new entry from the word, a neighbour or the head
    always_comb
    begin
        data_next = data_reg;
        case (ctrl.mode)
            MODE_INSERT:
            begin
                if (MY_IDX == ctrl.idx)
                    data_next = word;
                else if (MY_IDX > ctrl.idx)
                    data_next = prev;
            end
            MODE_DELETE:
            begin
                if (MY_IDX >= ctrl.idx)
                    data_next = next;
            end
            MODE_ROTATE:
            begin
                if (MY_IDX1 == ctrl.cnt)
                    data_next = head;
                else if (MY_IDX < ctrl.cnt)
                    data_next = next;
            end
            default:
                data_next = data_reg;
        endcase
    end

    // Hold the entry
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule
`default_nettype wire

// File: hdl/positional_list_insert_delete_core.sv
// Insert, delete and bad requests give their single result in the cycle after acceptance.
// Throughput: one such request per cycle unless rsp_ready stalls; the chain shifts in that cycle.
// A dump of n entries gives n results, one per cycle unless rsp_ready stalls, the first from
// the dump state entered after acceptance; the next request waits for idle and a free slot.
// Reset (rst_n, async, low) empties the list; cell contents stay undefined until written.
// Status, length and last come from the output register, which frees on rsp_ready.
`default_nettype none
module positional_list_insert_delete_core
    import plc_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire      clk,
    input  wire      rst_n,
    input  wire      req_valid,
    output logic     req_ready,
    input  plc_req_t req,
    output logic     rsp_valid,
    input  wire      rsp_ready,
    output plc_rsp_t rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_DUMP = 2'b10
    } plc_state_t;

    plc_state_t        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  dump_idx_reg, dump_idx_next;
    logic              rsp_valid_reg, rsp_valid_next;
    plc_rsp_t          rsp_reg, rsp_next;
    plc_ctrl_t         ctrl;

    logic signed [DATA_W-1:0] cell_data [CAPACITY];

    logic              slot_free;
    logic              accept;
    logic [POS_W:0]    pos_ext;
    logic [POS_W:0]    cnt_ext;

    assign slot_free = !rsp_valid_reg || rsp_ready;
    assign req_ready = (state_reg == ST_IDLE) && slot_free;
    assign accept    = req_valid && req_ready;
    assign pos_ext   = {1'b0, req.position};
    assign cnt_ext   = (POS_W + 1)'(count_reg);

    // Decode requests, drive the chain and load the output register
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        dump_idx_next  = dump_idx_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        ctrl.mode      = MODE_HOLD;
        ctrl.idx       = req.position - POS_W'(1);
        ctrl.cnt       = POS_W'(count_reg);

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    rsp_valid_next    = 1'b1;
                    rsp_next.data_out = '0;
                    rsp_next.last     = 1'b1;
                    rsp_next.status   = STS_INVALID;
                    case (plc_op_t'(req.op))
                        OP_INSERT:
                        begin
                            if (count_reg >= CAP_CNT)
                                rsp_next.status = STS_FULL;
                            else if (pos_ext != '0 && pos_ext <= cnt_ext + 1'b1)
                            begin
                                rsp_next.status = STS_OK;
                                ctrl.mode       = MODE_INSERT;
                                count_next      = count_reg + 1'b1;
                            end
                        end
                        OP_DELETE:
                        begin
                            if (pos_ext != '0 && pos_ext <= cnt_ext)
                            begin
                                rsp_next.status = STS_OK;
                                ctrl.mode       = MODE_DELETE;
                                count_next      = count_reg - 1'b1;
                            end
                        end
                        OP_DUMP:
                        begin
                            if (count_reg == '0)
                                rsp_next.status = STS_EMPTY;
                            else
                            begin
                                // First entry goes out from the dump state
                                rsp_valid_next = rsp_valid_reg && !rsp_ready;
                                dump_idx_next  = '0;
                                state_next     = ST_DUMP;
                            end
                        end
                        default:
                            rsp_next.status = STS_INVALID;
                    endcase
                    rsp_next.length = POS_W'(count_next);
                end
            end
            ST_DUMP:
            begin
                if (slot_free)
                begin
                    // Emit the head and rotate the chain by one place
                    rsp_valid_next    = 1'b1;
                    rsp_next.status   = STS_OK;
                    rsp_next.data_out = cell_data[0];
                    rsp_next.length   = POS_W'(count_reg);
                    rsp_next.last     = (dump_idx_reg == count_reg - 1'b1);
                    ctrl.mode         = MODE_ROTATE;
                    dump_idx_next     = dump_idx_reg + 1'b1;
                    if (dump_idx_reg == count_reg - 1'b1)
                        state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Advance control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            dump_idx_reg  <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            dump_idx_reg  <= dump_idx_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Hold the response word
    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Chain of cells, each linked to its neighbours
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        plc_cell #(
            .IDX (g)
        ) u_cell (
            .clk  (clk),
            .ctrl (ctrl),
            .word (req.value),
            .prev (cell_data[(g == 0) ? 0 : g - 1]),
            .next (cell_data[(g == CAPACITY - 1) ? g : g + 1]),
            .head (cell_data[0]),
            .data (cell_data[g])
        );
    end

    // Checks on list bookkeeping
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_CNT)
        else $error("entry count beyond capacity");

    a_dump_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DUMP |-> count_reg != '0)
        else $error("dump of an empty list in progress");

    a_not_last_in_dump: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && !rsp_reg.last |-> state_reg == ST_DUMP)
        else $error("unfinished result outside a dump");

    a_count_stable_dump: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DUMP |=> $stable(count_reg))
        else $error("entry count changed during a dump");

endmodule
`default_nettype wire
